### rtl/gpioc_pkg.sv
// Shared types and constants of the GPIO controller: request codes, bus map,
// status word layout, interrupt type codes, controller states and the
// command and status structs between controller and datapath.
package gpioc_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	localparam logic [11:0] OFS_SET     = 12'h000;
	localparam logic [11:0] OFS_CLR     = 12'h004;
	localparam logic [11:0] OFS_TOG     = 12'h008;
	localparam logic [11:0] OFS_INBANK  = 12'h010;
	localparam logic [11:0] OFS_OUTBANK = 12'h020;
	localparam logic [11:0] OFS_SELECT  = 12'h030;
	localparam logic [11:0] OFS_STATUS  = 12'h034;
	localparam logic [11:0] OFS_DIR     = 12'h038;
	localparam logic [11:0] OFS_INT     = 12'h03C;
	localparam logic [11:0] OFS_ACK     = 12'h040;

	// Status word and write data field positions
	localparam int ST_DIR_LSB  = 24;
	localparam int ST_TYPE_LSB = 17;
	localparam int ST_EN_BIT   = 16;
	localparam int ST_IN_BIT   = 12;
	localparam int ST_OUT_BIT  = 8;

	localparam logic [2:0] IRQ_TYPE_LOW  = 3'd0;
	localparam logic [2:0] IRQ_TYPE_HIGH = 3'd4;
	localparam int IRQ_FALL_BIT = 0;
	localparam int IRQ_RISE_BIT = 1;

	localparam int BUS_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_EVAL
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic eval;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic need_eval;
	} dp_status_t;

endpackage

### rtl/gpioc_ctrl.sv
// Controller state machine of the GPIO controller.
// Sequences capture, register access and interrupt evaluation; uses gpioc_pkg.
module gpioc_ctrl
	import gpioc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_next = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				if (status.need_eval) begin
					state_next = ST_EVAL;
				end else begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				cmd.finish = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/gpioc_datapath.sv
// Datapath of the GPIO controller: request registers, per-pin state, register
// access and the parallel loopback and interrupt evaluation; uses gpioc_pkg.
module gpioc_datapath
	import gpioc_pkg::*;
#(
	parameter int N_PINS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	input  logic [1:0]        op,
	input  logic [11:0]       bus_offset,
	input  logic [BUS_W-1:0]  write_data,
	input  logic [5:0]        pin_index,
	input  logic              pin_level,
	output logic              done,
	output logic [BUS_W-1:0]  read_data,
	output logic [BUS_W-1:0]  irq_pulses,
	output logic              bad_offset
);

	localparam int NB = (N_PINS < BUS_W) ? N_PINS : BUS_W;
	localparam logic [N_PINS-1:0] LANE_ONE = (N_PINS)'(1);

	// request registers
	logic [1:0]       op_q;
	logic [11:0]      ofs_q;
	logic [BUS_W-1:0] data_q;
	logic [5:0]       pidx_q;
	logic             plev_q;

	// per-pin and block state
	logic [5:0]        sel_q;
	logic [1:0]        dir_q [N_PINS];
	logic [2:0]        itype_q [N_PINS];
	logic [N_PINS-1:0] en_q;
	logic [N_PINS-1:0] out_q;
	logic [N_PINS-1:0] in_q;
	logic [N_PINS-1:0] blk_q;

	logic             done_q;
	logic [BUS_W-1:0] rd_q;
	logic [BUS_W-1:0] irq_q;
	logic             bad_q;

	logic is_read, is_write, is_event;
	logic read_ok, write_ok, pre_eval;
	logic [5:0] wsel;
	logic [BUS_W-1:0] rd_next;

	logic [N_PINS-1:0] loop_m, new_v, lvl_old, lvl_new, before_m;
	logic [N_PINS-1:0] fire_lvl, edge_hit, lowm;
	logic              any_loop;
	logic [BUS_W-1:0]  irq_next;

	assign is_read  = (op_q == OP_READ);
	assign is_write = (op_q == OP_WRITE);
	assign is_event = (op_q == OP_EVENT);
	assign wsel     = data_q[5:0];
	assign pre_eval = is_write && (ofs_q == OFS_INT || ofs_q == OFS_ACK);
	assign status.need_eval = is_write || is_event;

	always_comb begin
		read_ok = ofs_q inside {OFS_STATUS, OFS_OUTBANK, OFS_INBANK};
		case (ofs_q)
			OFS_SET, OFS_CLR, OFS_TOG, OFS_OUTBANK,
			OFS_SELECT, OFS_DIR, OFS_INT, OFS_ACK: write_ok = 1'b1;
			default: write_ok = 1'b0;
		endcase
	end

	// read data, from the state before the request
	always_comb begin
		rd_next = '0;
		case (ofs_q)
			OFS_STATUS: begin
				for (int i = 0; i < N_PINS; i++) begin
					if (sel_q == 6'(i)) begin
						rd_next[ST_DIR_LSB +: 2]  = dir_q[i];
						rd_next[ST_TYPE_LSB +: 3] = itype_q[i];
						rd_next[ST_EN_BIT]        = en_q[i];
						rd_next[ST_IN_BIT]        = in_q[i];
						rd_next[ST_OUT_BIT]       = out_q[i];
					end
				end
				rd_next[5:0] = sel_q;
			end
			OFS_OUTBANK: begin
				for (int i = 0; i < NB; i++) rd_next[i] = out_q[i];
			end
			OFS_INBANK: begin
				for (int i = 0; i < NB; i++) rd_next[i] = in_q[i];
			end
			default: rd_next = '0;
		endcase
	end

	// Loopback steps run in ascending pin order, each followed by a full
	// evaluation. A pin's level fires if its old level qualifies at an
	// evaluation before its own step, or its new level qualifies at all.
	always_comb begin
		loop_m = '0;
		new_v  = '0;
		for (int i = 0; i < N_PINS; i++) begin
			if (is_write) begin
				loop_m[i] = dir_q[i][0];
				new_v[i]  = out_q[i];
			end else if (is_event) begin
				loop_m[i] = (pidx_q == 6'(i));
				new_v[i]  = plev_q;
			end
		end
		any_loop = |loop_m;
		lowm = '0;
		for (int i = 0; i < N_PINS; i++) begin
			lowm = (LANE_ONE << i) - LANE_ONE;
			before_m[i] = pre_eval || (|(loop_m & lowm));
			lvl_old[i] = en_q[i] && !blk_q[i] &&
				((itype_q[i] == IRQ_TYPE_LOW && !in_q[i]) ||
				 (itype_q[i] == IRQ_TYPE_HIGH && in_q[i]));
			lvl_new[i] = en_q[i] && !blk_q[i] &&
				((itype_q[i] == IRQ_TYPE_LOW && !new_v[i]) ||
				 (itype_q[i] == IRQ_TYPE_HIGH && new_v[i]));
			if (loop_m[i]) begin
				fire_lvl[i] = (lvl_old[i] && before_m[i]) || lvl_new[i];
			end else begin
				fire_lvl[i] = lvl_old[i] && (pre_eval || any_loop);
			end
			edge_hit[i] = loop_m[i] && en_q[i] &&
				((itype_q[i][IRQ_FALL_BIT] && in_q[i] && !new_v[i]) ||
				 (itype_q[i][IRQ_RISE_BIT] && !in_q[i] && new_v[i]));
		end
		irq_next = '0;
		for (int i = 0; i < NB; i++) irq_next[i] = fire_lvl[i] || edge_hit[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			ofs_q  <= bus_offset;
			data_q <= write_data;
			pidx_q <= pin_index;
			plev_q <= pin_level;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			rd_q  <= is_read ? rd_next : '0;
			bad_q <= (is_read && !read_ok) || (is_write && !write_ok);
			irq_q <= '0;
		end else if (cmd.eval) begin
			irq_q <= irq_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			sel_q  <= '0;
			en_q   <= '0;
			out_q  <= '0;
			in_q   <= '0;
			blk_q  <= '0;
			for (int i = 0; i < N_PINS; i++) begin
				dir_q[i]   <= '0;
				itype_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.finish;
			if (cmd.apply && is_write) begin
				case (ofs_q)
					OFS_SELECT: sel_q <= wsel;
					OFS_DIR: begin
						sel_q <= wsel;
						for (int i = 0; i < N_PINS; i++)
							if (wsel == 6'(i)) dir_q[i] <= data_q[ST_DIR_LSB +: 2];
					end
					OFS_INT: begin
						sel_q <= wsel;
						for (int i = 0; i < N_PINS; i++) begin
							if (wsel == 6'(i)) begin
								itype_q[i] <= data_q[ST_TYPE_LSB +: 3];
								en_q[i]    <= data_q[ST_EN_BIT];
							end
						end
					end
					OFS_SET, OFS_CLR, OFS_TOG: begin
						sel_q <= wsel;
						for (int i = 0; i < N_PINS; i++) begin
							if (wsel == 6'(i)) begin
								if (ofs_q == OFS_SET) out_q[i] <= 1'b1;
								else if (ofs_q == OFS_CLR) out_q[i] <= 1'b0;
								else out_q[i] <= !out_q[i];
							end
						end
					end
					OFS_OUTBANK: begin
						for (int i = 0; i < NB; i++) out_q[i] <= data_q[i];
					end
					OFS_ACK: begin
						for (int i = 0; i < N_PINS; i++)
							if (data_q[7:0] == 8'(i)) blk_q[i] <= 1'b0;
					end
					default: ;
				endcase
			end else if (cmd.eval) begin
				for (int i = 0; i < N_PINS; i++) begin
					if (loop_m[i]) in_q[i] <= new_v[i];
				end
				blk_q <= blk_q | fire_lvl;
			end
		end
	end

	assign done       = done_q;
	assign read_data  = rd_q;
	assign irq_pulses = irq_q;
	assign bad_offset = bad_q;

endmodule

### rtl/gpio_controller_with_pin_interrupts.sv
// Top level of the GPIO controller with per-pin interrupts.
// Joins gpioc_ctrl and gpioc_datapath; uses gpioc_pkg.
//
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        op, bus_offset, write_data, pin_index, pin_level
// result    out        done (one cycle)     read_data, irq_pulses, bad_offset
//
// A read captures the request and then does the register access before its done strobe;
// a write or pin event captures, does the register access, and then the loopback
// and interrupt evaluation over all pins at once in the datapath.
// busy is high from acceptance until the cycle of done; a new request may be
// accepted in the cycle that done is shown. The receiver cannot stall.
// Reset clears the pin select and every pin's state.
module gpio_controller_with_pin_interrupts
	import gpioc_pkg::*;
#(
	parameter int N_PINS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [11:0]      bus_offset,
	input  logic [BUS_W-1:0] write_data,
	input  logic [5:0]       pin_index,
	input  logic             pin_level,
	output logic             done,
	output logic [BUS_W-1:0] read_data,
	output logic [BUS_W-1:0] irq_pulses,
	output logic             bad_offset
);

	dp_cmd_t    cmd;
	dp_status_t status;

	gpioc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	gpioc_datapath #(
		.N_PINS (N_PINS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.bus_offset (bus_offset),
		.write_data (write_data),
		.pin_index  (pin_index),
		.pin_level  (pin_level),
		.done       (done),
		.read_data  (read_data),
		.irq_pulses (irq_pulses),
		.bad_offset (bad_offset)
	);

endmodule

### sim/gpio_controller_with_pin_interrupts_tb.sv
`timescale 1ns / 100ps
// Testbench for the GPIO controller with per-pin interrupts: bus reads, writes and
// pin events go in by the start/busy handshake and responses are scored against a
// shadow of the pin registers kept in a class. Depends on gpioc_pkg and the RTL top.
module gpio_controller_with_pin_interrupts_tb;
	import gpioc_pkg::*;

	localparam int NP = 32;
	localparam int N_ITEMS = 1200;

	typedef struct packed {
		logic [BUS_W-1:0] rd;
		logic [BUS_W-1:0] irq;
		logic             bad;
	} gpio_resp_t;

	// Shadow of the pin registers; predicts each response and checks it on arrival
	class gpio_scoreboard;
		logic [5:0] pin_sel;
		logic [1:0] dir [NP];
		logic [2:0] itype [NP];
		logic       en [NP];
		logic       out_lvl [NP];
		logic       in_lvl [NP];
		logic       blocked [NP];
		gpio_resp_t pending[$];
		int         errors;

		function new();
			pin_sel = '0;
			errors = 0;
			for (int i = 0; i < NP; i++) begin
				dir[i] = '0;
				itype[i] = '0;
				en[i] = 1'b0;
				out_lvl[i] = 1'b0;
				in_lvl[i] = 1'b0;
				blocked[i] = 1'b0;
			end
		endfunction

		// Scan all pins; an edge counts only for edge_pin, level types fire once
		function logic [BUS_W-1:0] scan_irq(input int edge_pin, input bit rise, input bit fall);
			logic [BUS_W-1:0] m;
			bit fe, re, lo, hi;
			m = '0;
			for (int i = 0; i < NP; i++) begin
				fe = itype[i][IRQ_FALL_BIT] && fall && i == edge_pin && en[i];
				re = itype[i][IRQ_RISE_BIT] && rise && i == edge_pin && en[i];
				lo = itype[i] == IRQ_TYPE_LOW && !in_lvl[i] && !blocked[i] && en[i];
				hi = itype[i] == IRQ_TYPE_HIGH && in_lvl[i] && !blocked[i] && en[i];
				if (lo || hi)
					blocked[i] = 1'b1;
				if (fe || re || lo || hi)
					m[i] = 1'b1;
			end
			return m;
		endfunction

		function logic [BUS_W-1:0] drive_pin(input int p, input bit lvl);
			bit rise, fall;
			rise = !in_lvl[p] && lvl;
			fall = in_lvl[p] && !lvl;
			in_lvl[p] = lvl;
			return scan_irq(p, rise, fall);
		endfunction

		function void note_request(input logic [1:0] o, input logic [11:0] ofs,
				input logic [31:0] d, input logic [5:0] pidx, input logic plev);
			gpio_resp_t r;
			r = '0;
			if (o == OP_READ) begin
				case (ofs)
					OFS_STATUS: begin
						if (pin_sel < NP) begin
							r.rd[ST_DIR_LSB +: 2] = dir[pin_sel];
							r.rd[ST_TYPE_LSB +: 3] = itype[pin_sel];
							r.rd[ST_EN_BIT] = en[pin_sel];
							r.rd[ST_IN_BIT] = in_lvl[pin_sel];
							r.rd[ST_OUT_BIT] = out_lvl[pin_sel];
						end
						r.rd[5:0] = pin_sel;
					end
					OFS_OUTBANK: for (int i = 0; i < NP; i++) r.rd[i] = out_lvl[i];
					OFS_INBANK: for (int i = 0; i < NP; i++) r.rd[i] = in_lvl[i];
					default: r.bad = 1'b1;
				endcase
			end else if (o == OP_WRITE) begin
				case (ofs)
					OFS_SELECT: pin_sel = d[5:0];
					OFS_DIR: begin
						pin_sel = d[5:0];
						if (pin_sel < NP)
							dir[pin_sel] = d[ST_DIR_LSB +: 2];
					end
					OFS_INT: begin
						pin_sel = d[5:0];
						if (pin_sel < NP) begin
							itype[pin_sel] = d[ST_TYPE_LSB +: 3];
							en[pin_sel] = d[ST_EN_BIT];
						end
						r.irq |= scan_irq(NP, 1'b0, 1'b0);
					end
					OFS_SET, OFS_CLR, OFS_TOG: begin
						pin_sel = d[5:0];
						if (pin_sel < NP) begin
							if (ofs == OFS_SET)
								out_lvl[pin_sel] = 1'b1;
							else if (ofs == OFS_CLR)
								out_lvl[pin_sel] = 1'b0;
							else
								out_lvl[pin_sel] = !out_lvl[pin_sel];
						end
					end
					OFS_OUTBANK: for (int i = 0; i < NP; i++) out_lvl[i] = d[i];
					OFS_ACK: begin
						if (d[7:0] < NP)
							blocked[d[7:0]] = 1'b0;
						r.irq |= scan_irq(NP, 1'b0, 1'b0);
					end
					default: r.bad = 1'b1;
				endcase
				// loop outputs back to inputs, lowest pin first
				for (int i = 0; i < NP; i++) begin
					if (dir[i][0])
						r.irq |= drive_pin(i, out_lvl[i]);
				end
			end else if (o == OP_EVENT) begin
				if (pidx < NP)
					r.irq |= drive_pin(pidx, plev);
			end
			pending.push_back(r);
		endfunction

		function void check_response(input logic [BUS_W-1:0] rd, input logic [BUS_W-1:0] irq,
				input logic bad);
			gpio_resp_t exp_r;
			if (pending.size() == 0) begin
				$error("response with no request pending");
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (rd !== exp_r.rd) begin
				$error("read_data: expected %h, got %h", exp_r.rd, rd);
				errors++;
			end
			if (irq !== exp_r.irq) begin
				$error("irq_pulses: expected %h, got %h", exp_r.irq, irq);
				errors++;
			end
			if (bad !== exp_r.bad) begin
				$error("bad_offset: expected %b, got %b", exp_r.bad, bad);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [1:0]       op = OP_READ;
	logic [11:0]      bus_offset = '0;
	logic [BUS_W-1:0] write_data = '0;
	logic [5:0]       pin_index = '0;
	logic             pin_level = 1'b0;
	logic             done;
	logic [BUS_W-1:0] read_data;
	logic [BUS_W-1:0] irq_pulses;
	logic             bad_offset;

	gpio_scoreboard sb = new();
	int  n_sent = 0;
	bit  no_idle = 1'b0;

	gpio_controller_with_pin_interrupts #(.N_PINS(NP)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.bus_offset (bus_offset),
		.write_data (write_data),
		.pin_index  (pin_index),
		.pin_level  (pin_level),
		.done       (done),
		.read_data  (read_data),
		.irq_pulses (irq_pulses),
		.bad_offset (bad_offset)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0)
			sb.check_response(read_data, irq_pulses, bad_offset);
	end

	// Called at a rising edge; returns at the edge that accepts the request
	task automatic send_request(input logic [1:0] o, input logic [11:0] ofs,
			input logic [31:0] d, input logic [5:0] pidx, input logic plev);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		bus_offset <= ofs;
		write_data <= d;
		pin_index <= pidx;
		pin_level <= plev;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(o, ofs, d, pidx, plev);
		n_sent++;
	endtask

	task automatic bus_write(input logic [11:0] ofs, input logic [31:0] d);
		send_request(OP_WRITE, ofs, d, 6'($urandom), 1'($urandom));
	endtask

	task automatic bus_read(input logic [11:0] ofs);
		send_request(OP_READ, ofs, $urandom, 6'($urandom), 1'($urandom));
	endtask

	task automatic pin_event(input logic [5:0] p, input logic lvl);
		send_request(OP_EVENT, 12'($urandom), $urandom, p, lvl);
	endtask

	// Mostly a few hot pins, now and then one beyond the pin count
	function automatic logic [5:0] pick_pin();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 6'($urandom_range(32, 63));
		else if (r < 12)
			return 6'($urandom_range(0, 7));
		return 6'($urandom_range(0, 31));
	endfunction

	function automatic logic [2:0] pick_type();
		case ($urandom_range(0, 9))
			0, 1: return IRQ_TYPE_LOW;
			2, 3: return IRQ_TYPE_HIGH;
			4: return 3'(1 << IRQ_FALL_BIT);
			5: return 3'(1 << IRQ_RISE_BIT);
			6: return 3'((1 << IRQ_FALL_BIT) | (1 << IRQ_RISE_BIT));
			default: return 3'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [31:0] sel_word(input logic [5:0] p);
		logic [31:0] w;
		w = $urandom;
		w[5:0] = p;
		return w;
	endfunction

	function automatic logic [31:0] int_word(input logic [5:0] p, input logic [2:0] t,
			input logic e);
		logic [31:0] w;
		w = sel_word(p);
		w[ST_TYPE_LSB +: 3] = t;
		w[ST_EN_BIT] = e;
		return w;
	endfunction

	function automatic logic [31:0] dir_word(input logic [5:0] p, input logic [1:0] dv);
		logic [31:0] w;
		w = sel_word(p);
		w[ST_DIR_LSB +: 2] = dv;
		return w;
	endfunction

	function automatic logic [31:0] ack_word(input logic [7:0] p);
		logic [31:0] w;
		w = $urandom;
		w[7:0] = p;
		return w;
	endfunction

	task automatic random_item();
		int pick;
		logic [5:0] p;
		logic [7:0] ap;
		pick = $urandom_range(0, 99);
		p = pick_pin();
		if (pick < 22) begin
			pin_event(p, 1'($urandom));
		end else if (pick < 32) begin
			bus_write(OFS_INT, int_word(p, pick_type(), $urandom_range(0, 3) != 0));
		end else if (pick < 40) begin
			// configure, wiggle the pin, inspect, acknowledge
			bus_write(OFS_INT, int_word(p, pick_type(), 1'b1));
			repeat ($urandom_range(2, 4)) pin_event(p, 1'($urandom));
			bus_read(OFS_STATUS);
			bus_write(OFS_ACK, ack_word({2'b00, p}));
		end else if (pick < 46) begin
			ap = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(32, 255)) : {2'b00, p};
			bus_write(OFS_ACK, ack_word(ap));
		end else if (pick < 52) begin
			bus_write(OFS_DIR, dir_word(p, 2'($urandom)));
		end else if (pick < 58) begin
			// loopback pin driven by its own output
			bus_write(OFS_DIR, dir_word(p, 2'b01));
			bus_write(OFS_INT, int_word(p, pick_type(), 1'b1));
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 2))
					0: bus_write(OFS_SET, sel_word(p));
					1: bus_write(OFS_CLR, sel_word(p));
					default: bus_write(OFS_TOG, sel_word(p));
				endcase
			end
			bus_write(OFS_ACK, ack_word({2'b00, p}));
		end else if (pick < 68) begin
			case ($urandom_range(0, 2))
				0: bus_write(OFS_SET, sel_word(p));
				1: bus_write(OFS_CLR, sel_word(p));
				default: bus_write(OFS_TOG, sel_word(p));
			endcase
		end else if (pick < 71) begin
			bus_write(OFS_OUTBANK, $urandom);
		end else if (pick < 74) begin
			bus_write(OFS_SELECT, sel_word(p));
		end else if (pick < 90) begin
			case ($urandom_range(0, 4))
				0, 1: bus_read(OFS_STATUS);
				2: bus_read(OFS_INBANK);
				3: bus_read(OFS_OUTBANK);
				default: bus_read(12'($urandom_range(0, 4095)));
			endcase
		end else begin
			send_request(2'($urandom_range(0, 2)), 12'($urandom_range(0, 4095)), $urandom,
				6'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bus_read(OFS_STATUS);
		bus_read(OFS_INBANK);
		bus_read(OFS_OUTBANK);
		bus_read(12'hFFF);
		bus_write(OFS_STATUS, 32'hFFFF_FFFF);
		bus_write(OFS_INBANK, 32'h0);
		// low-level type fires at once on an enabled pin that reads low
		bus_write(OFS_INT, int_word(6'd3, IRQ_TYPE_LOW, 1'b1));
		bus_write(OFS_INT, int_word(6'd5, IRQ_TYPE_HIGH, 1'b1));
		pin_event(6'd5, 1'b1);
		pin_event(6'd5, 1'b0);
		pin_event(6'd5, 1'b1);
		bus_write(OFS_ACK, ack_word(8'd5));
		bus_write(OFS_INT, int_word(6'd31, 3'((1 << IRQ_FALL_BIT) | (1 << IRQ_RISE_BIT)), 1'b1));
		pin_event(6'd31, 1'b1);
		pin_event(6'd31, 1'b0);
		bus_write(OFS_DIR, dir_word(6'd9, 2'b01));
		bus_write(OFS_SET, sel_word(6'd9));
		bus_write(OFS_TOG, sel_word(6'd9));
		bus_write(OFS_CLR, sel_word(6'd9));
		bus_write(OFS_OUTBANK, 32'hFFFF_FFFF);
		bus_read(OFS_OUTBANK);
		// pins beyond the pin count: select shows, everything else ignored
		bus_write(OFS_SELECT, sel_word(6'd45));
		bus_read(OFS_STATUS);
		pin_event(6'd63, 1'b1);
		bus_write(OFS_ACK, ack_word(8'd200));

		while (n_sent < N_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			random_item();
		end
		start <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0)
			$error("%0d responses never arrived", sb.pending.size());
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
